/* sv/covariant_piola_basis_map_core_assert.svh */
// Assertion macros for the covariant Piola basis map core.
// Used by the top level only; no other dependencies.
`ifndef COVARIANT_PIOLA_BASIS_MAP_CORE_ASSERT_SVH
`define COVARIANT_PIOLA_BASIS_MAP_CORE_ASSERT_SVH

// Check that a condition implies a consequence on the same edge.
`define CPBM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpbm check failed");

// Check that a condition implies a consequence on the next edge.
`define CPBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpbm check failed");

`endif

/* sv/cpbm_pkg.sv */
// Shared types and constants for the covariant Piola basis map core.
// No dependencies.
package cpbm_pkg;

  localparam int IO_BITS = 32;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO_MEAS = 2'd1,
    ERR_SINGULAR = 2'd2,
    ERR_SAT      = 2'd3
  } err_t;

  typedef enum logic {
    CMD_LOAD      = 1'b0,
    CMD_TRANSFORM = 1'b1
  } cmd_t;

  // Input beat payload.
  typedef struct packed {
    logic                      command;
    logic signed [IO_BITS-1:0] dxdu;
    logic signed [IO_BITS-1:0] dydu;
    logic signed [IO_BITS-1:0] dzdu;
    logic signed [IO_BITS-1:0] dxdv;
    logic signed [IO_BITS-1:0] dydv;
    logic signed [IO_BITS-1:0] dzdv;
    logic signed [IO_BITS-1:0] surface_measure;
    logic signed [IO_BITS-1:0] basis_u;
    logic signed [IO_BITS-1:0] basis_v;
    logic                      last_in;
  } in_beat_t;

  // Output beat payload.
  typedef struct packed {
    logic signed [IO_BITS-1:0] out_x;
    logic signed [IO_BITS-1:0] out_y;
    logic signed [IO_BITS-1:0] out_z;
    logic                      last_out;
    logic [1:0]                error_code;
  } out_beat_t;

  // Shared ALU operations.
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_DIV = 2'd3
  } alu_op_t;

endpackage

/* sv/cpbm_stream_if.sv */
// Valid/ready stream channel carrying one payload type.
// No dependencies; the payload type is a parameter.
interface cpbm_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/cpbm_alu.sv */
// Shared fixed-point unit: saturating add/sub, rounded multiply, rounded divide.
// Multiply sums four half-word partial products; divide is one bit a cycle.
// Depends on cpbm_pkg.
module cpbm_alu import cpbm_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  alu_op_t                     op,
  input  logic signed [WORD_BITS-1:0] a,
  input  logic signed [WORD_BITS-1:0] b,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] res,
  output logic                        sat
);
  localparam int HB   = (WORD_BITS + 1) / 2;          // half width for partial products
  localparam int PW   = 2 * WORD_BITS;                // product width
  localparam int NW   = WORD_BITS + FRAC_BITS + 1;    // dividend width
  localparam int CW   = $clog2(NW + 1);
  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_PACK} st_t;

  st_t                 state;
  logic [1:0]          pp;
  logic [PW:0]         acc;
  logic [WORD_BITS-1:0] ma, mb;
  logic                neg;
  logic [NW-1:0]       num;
  logic [WORD_BITS:0]  rem;
  logic [CW-1:0]       cnt;
  logic                is_div;

  logic [WORD_BITS:0]  sum_w;
  logic [HB-1:0]       pa, pb;
  logic [2*HB-1:0]     pprod;
  logic [PW:0]         pshift;
  logic [WORD_BITS+1:0] rem_sh;
  logic [WORD_BITS+1:0] rem_sub;
  logic [PW:0]         rounded;
  logic [PW:0]         lim;

  // Magnitudes of the operands.
  function automatic logic [WORD_BITS-1:0] mag(input logic signed [WORD_BITS-1:0] x);
    mag = x[WORD_BITS-1] ? (~x + 1'b1) : x;
  endfunction

  // Select half-words for one partial product.
  always_comb begin
    pa = pp[0] ? HB'(ma >> HB) : ma[HB-1:0];
    pb = pp[1] ? HB'(mb >> HB) : mb[HB-1:0];
    pprod = pa * pb;
    pshift = (PW+1)'(pprod) << (HB * (pp[0] + pp[1]));
    rem_sh = {rem, num[NW-1]};
    rem_sub = rem_sh - {2'b0, mb};
    sum_w = (op == OP_SUB) ? {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b}
                           : {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    rounded = is_div ? acc : ((acc + ((PW+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS);
    lim = (PW+1)'(WMAX) + (PW+1)'(neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            ma  <= mag(a);
            mb  <= mag(b);
            neg <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
            acc <= '0;
            pp  <= '0;
            is_div <= (op == OP_DIV);
            case (op)
              OP_ADD, OP_SUB: begin
                done <= 1'b1;
                if (sum_w[WORD_BITS] != sum_w[WORD_BITS-1]) begin
                  res <= sum_w[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : WMAX;
                  sat <= 1'b1;
                end else begin
                  res <= sum_w[WORD_BITS-1:0];
                  sat <= 1'b0;
                end
              end
              OP_MUL: state <= S_MUL;
              OP_DIV: begin
                // |a|<<F + |b|/2 as the dividend
                num <= ({1'b0, mag(a), {FRAC_BITS{1'b0}}}) + NW'(mag(b) >> 1);
                rem <= '0;
                cnt <= CW'(NW);
                state <= S_DIV;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          acc <= acc + pshift;
          pp  <= pp + 2'd1;
          if (pp == 2'd3) state <= S_PACK;
        end
        S_DIV: begin
          num <= num << 1;
          if (!rem_sub[WORD_BITS+1]) begin
            rem <= rem_sub[WORD_BITS:0];
            acc <= {acc[PW-1:0], 1'b1};
          end else begin
            rem <= rem_sh[WORD_BITS:0];
            acc <= {acc[PW-1:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) state <= S_PACK;
        end
        S_PACK: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (rounded > lim) begin
            sat <= 1'b1;
            res <= neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : WMAX;
          end else begin
            sat <= 1'b0;
            res <= neg ? (~rounded[WORD_BITS-1:0] + 1'b1) : rounded[WORD_BITS-1:0];
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/covariant_piola_basis_map_core.sv */
// Covariant Piola basis map core: geometry load sequencer and basis transform.
// Depends on cpbm_pkg, cpbm_stream_if, cpbm_alu and the assertion macro header.
//
// One beat at a time. A transform runs 6 multiplies and 3 adds on the shared unit; a
// geometry load runs 21 multiplies, 11 adds or subtracts and 9 divides. A load with
// zero measure and a transform after a failed load finish without the shared unit.
// A result beat waits in an output register; the next input is taken once it has
// been handed off.
`include "covariant_piola_basis_map_core_assert.svh"
module covariant_piola_basis_map_core import cpbm_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  cpbm_stream_if.sink   in_ch,
  cpbm_stream_if.source out_ch
);
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Register file slots.
  typedef enum logic [4:0] {
    R_A0, R_A1, R_A2, R_B0, R_B1, R_B2, R_N0, R_N1, R_N2,
    R_MS, R_T0, R_T1, R_C0, R_C1, R_C2, R_DT, R_U, R_V,
    R_I0, R_I1, R_I2, R_I3, R_I4, R_I5, R_ZERO
  } reg_id_t;

  typedef struct packed {
    alu_op_t op;
    reg_id_t sa;
    reg_id_t sb;
    reg_id_t dst;
  } uop_t;

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_CHECK, S_OUT} st_t;

  st_t                          state;
  logic signed [WORD_BITS-1:0]  rf [25];
  logic signed [WORD_BITS-1:0]  inv [6];
  logic [1:0]                   geo_status;
  logic                         is_xform;
  logic [6:0]                   pc;
  logic                         sat_acc;
  logic                         last_q;
  out_beat_t                    obuf;
  logic                         ovalid;

  logic                         alu_start, alu_done, alu_sat;
  logic signed [WORD_BITS-1:0]  alu_res;
  uop_t                         uop;
  logic [6:0]                   last_pc;

  // Clamp a 32-bit field into the word range.
  function automatic logic signed [WORD_BITS-1:0] fld(input logic signed [IO_BITS-1:0] x,
                                                      output logic s);
    logic signed [63:0] w;
    w = 64'(x);
    s = 1'b0;
    if (w > 64'(WMAX)) begin
      s = 1'b1;
      fld = WMAX;
    end else if (w < 64'(WMIN)) begin
      s = 1'b1;
      fld = WMIN;
    end else begin
      fld = WORD_BITS'(x);
    end
  endfunction

  // Clamp a word into the 32-bit output range.
  function automatic logic signed [IO_BITS-1:0] oclamp(input logic signed [WORD_BITS-1:0] x,
                                                       output logic s);
    logic signed [63:0] w;
    w = 64'(x);
    s = 1'b0;
    if (w > 64'sh7FFFFFFF) begin
      s = 1'b1;
      oclamp = 32'sh7FFFFFFF;
    end else if (w < -64'sh80000000) begin
      s = 1'b1;
      oclamp = 32'sh80000000;
    end else begin
      oclamp = IO_BITS'(x);
    end
  endfunction

  // Micro-program: geometry load, then transform at entry 80.
  function automatic uop_t prog(input logic [6:0] p);
    case (p)
      // normal row numerators
      7'd0:  prog = '{OP_MUL, R_A1, R_B2, R_T0};
      7'd1:  prog = '{OP_MUL, R_A2, R_B1, R_T1};
      7'd2:  prog = '{OP_SUB, R_T0, R_T1, R_T0};
      7'd3:  prog = '{OP_DIV, R_T0, R_MS, R_N0};
      7'd4:  prog = '{OP_MUL, R_A2, R_B0, R_T0};
      7'd5:  prog = '{OP_MUL, R_A0, R_B2, R_T1};
      7'd6:  prog = '{OP_SUB, R_T0, R_T1, R_T0};
      7'd7:  prog = '{OP_DIV, R_T0, R_MS, R_N1};
      7'd8:  prog = '{OP_MUL, R_A0, R_B1, R_T0};
      7'd9:  prog = '{OP_MUL, R_A1, R_B0, R_T1};
      7'd10: prog = '{OP_SUB, R_T0, R_T1, R_T0};
      7'd11: prog = '{OP_DIV, R_T0, R_MS, R_N2};
      // cofactors of row 0: C(0,c) from rows B,N
      7'd12: prog = '{OP_MUL, R_B1, R_N2, R_T0};
      7'd13: prog = '{OP_MUL, R_B2, R_N1, R_T1};
      7'd14: prog = '{OP_SUB, R_T0, R_T1, R_C0};
      7'd15: prog = '{OP_MUL, R_B2, R_N0, R_T0};
      7'd16: prog = '{OP_MUL, R_B0, R_N2, R_T1};
      7'd17: prog = '{OP_SUB, R_T0, R_T1, R_C1};
      7'd18: prog = '{OP_MUL, R_B0, R_N1, R_T0};
      7'd19: prog = '{OP_MUL, R_B1, R_N0, R_T1};
      7'd20: prog = '{OP_SUB, R_T0, R_T1, R_C2};
      // determinant
      7'd21: prog = '{OP_MUL, R_A0, R_C0, R_T0};
      7'd22: prog = '{OP_MUL, R_A1, R_C1, R_T1};
      7'd23: prog = '{OP_ADD, R_T0, R_T1, R_DT};
      7'd24: prog = '{OP_MUL, R_A2, R_C2, R_T0};
      7'd25: prog = '{OP_ADD, R_DT, R_T0, R_DT};
      // inverse column 0 = C(0,i)/det
      7'd26: prog = '{OP_DIV, R_C0, R_DT, R_I0};
      7'd27: prog = '{OP_DIV, R_C1, R_DT, R_I2};
      7'd28: prog = '{OP_DIV, R_C2, R_DT, R_I4};
      // column 1 = C(1,i)/det, C(1,c) from rows N,A
      7'd29: prog = '{OP_MUL, R_N1, R_A2, R_T0};
      7'd30: prog = '{OP_MUL, R_N2, R_A1, R_T1};
      7'd31: prog = '{OP_SUB, R_T0, R_T1, R_T0};
      7'd32: prog = '{OP_DIV, R_T0, R_DT, R_I1};
      7'd33: prog = '{OP_MUL, R_N2, R_A0, R_T0};
      7'd34: prog = '{OP_MUL, R_N0, R_A2, R_T1};
      7'd35: prog = '{OP_SUB, R_T0, R_T1, R_T0};
      7'd36: prog = '{OP_DIV, R_T0, R_DT, R_I3};
      7'd37: prog = '{OP_MUL, R_N0, R_A1, R_T0};
      7'd38: prog = '{OP_MUL, R_N1, R_A0, R_T1};
      7'd39: prog = '{OP_SUB, R_T0, R_T1, R_T0};
      7'd40: prog = '{OP_DIV, R_T0, R_DT, R_I5};
      // transform
      7'd80: prog = '{OP_MUL, R_I0, R_U, R_T0};
      7'd81: prog = '{OP_MUL, R_I1, R_V, R_T1};
      7'd82: prog = '{OP_ADD, R_T0, R_T1, R_C0};
      7'd83: prog = '{OP_MUL, R_I2, R_U, R_T0};
      7'd84: prog = '{OP_MUL, R_I3, R_V, R_T1};
      7'd85: prog = '{OP_ADD, R_T0, R_T1, R_C1};
      7'd86: prog = '{OP_MUL, R_I4, R_U, R_T0};
      7'd87: prog = '{OP_MUL, R_I5, R_V, R_T1};
      7'd88: prog = '{OP_ADD, R_T0, R_T1, R_C2};
      default: prog = '{OP_ADD, R_ZERO, R_ZERO, R_T0};
    endcase
  endfunction

  assign uop       = prog(pc);
  assign last_pc   = is_xform ? 7'd88 : 7'd40;
  assign alu_start = (state == S_ISSUE);

  cpbm_alu #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .op    (uop.op),
    .a     (rf[uop.sa]),
    .b     (rf[uop.sb]),
    .done  (alu_done),
    .res   (alu_res),
    .sat   (alu_sat)
  );

  assign in_ch.ready  = (state == S_IDLE) && !ovalid;
  assign out_ch.valid = ovalid;
  assign out_ch.data  = obuf;

  // Sequencer, register file and result holding.
  always_ff @(posedge clk) begin
    logic s0, s1, s2, s3, s4, s5, s6;
    logic signed [WORD_BITS-1:0] v0, v1, v2, v3, v4, v5, v6;
    logic signed [IO_BITS-1:0] ox, oy, oz;
    if (rst) begin
      state      <= S_IDLE;
      ovalid     <= 1'b0;
      geo_status <= ERR_OK;
      for (int i = 0; i < 6; i++) inv[i] <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            last_q <= in_ch.data.last_in;
            rf[R_ZERO] <= '0;
            if (in_ch.data.command == CMD_TRANSFORM) begin
              is_xform <= 1'b1;
              if (geo_status != ERR_OK) begin
                obuf   <= '{'0, '0, '0, in_ch.data.last_in, geo_status};
                ovalid <= 1'b1;
              end else begin
                v0 = fld(in_ch.data.basis_u, s0);
                v1 = fld(in_ch.data.basis_v, s1);
                rf[R_U] <= v0;
                rf[R_V] <= v1;
                rf[R_I0] <= inv[0]; rf[R_I1] <= inv[1]; rf[R_I2] <= inv[2];
                rf[R_I3] <= inv[3]; rf[R_I4] <= inv[4]; rf[R_I5] <= inv[5];
                sat_acc <= s0 | s1;
                pc      <= 7'd80;
                state   <= S_ISSUE;
              end
            end else begin
              is_xform <= 1'b0;
              v0 = fld(in_ch.data.dxdu, s0);
              v1 = fld(in_ch.data.dydu, s1);
              v2 = fld(in_ch.data.dzdu, s2);
              v3 = fld(in_ch.data.dxdv, s3);
              v4 = fld(in_ch.data.dydv, s4);
              v5 = fld(in_ch.data.dzdv, s5);
              v6 = fld(in_ch.data.surface_measure, s6);
              rf[R_A0] <= v0; rf[R_A1] <= v1; rf[R_A2] <= v2;
              rf[R_B0] <= v3; rf[R_B1] <= v4; rf[R_B2] <= v5;
              rf[R_MS] <= v6;
              sat_acc  <= s0 | s1 | s2 | s3 | s4 | s5 | s6;
              for (int i = 0; i < 6; i++) inv[i] <= '0;
              if (v6 == '0) begin
                geo_status <= ERR_ZERO_MEAS;
              end else begin
                pc    <= 7'd0;
                state <= S_ISSUE;
              end
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (alu_done) begin
            rf[uop.dst] <= alu_res;
            sat_acc     <= sat_acc | alu_sat;
            if (pc == last_pc) begin
              state <= is_xform ? S_OUT : S_CHECK;
            end else if (!is_xform && pc == 7'd25) begin
              state <= S_CHECK;
            end else begin
              pc    <= pc + 7'd1;
              state <= S_ISSUE;
            end
          end
        end
        S_CHECK: begin
          // after the determinant: test singularity; at the end: commit
          if (pc == 7'd25) begin
            if (rf[R_DT] == '0) begin
              geo_status <= ERR_SINGULAR;
              state      <= S_IDLE;
            end else begin
              pc    <= 7'd26;
              state <= S_ISSUE;
            end
          end else begin
            state <= S_IDLE;
            if (sat_acc) begin
              geo_status <= ERR_SAT;
            end else begin
              geo_status <= ERR_OK;
              inv[0] <= rf[R_I0]; inv[1] <= rf[R_I1]; inv[2] <= rf[R_I2];
              inv[3] <= rf[R_I3]; inv[4] <= rf[R_I4]; inv[5] <= rf[R_I5];
            end
          end
        end
        S_OUT: begin
          ox = oclamp(rf[R_C0], s0);
          oy = oclamp(rf[R_C1], s1);
          oz = oclamp(rf[R_C2], s2);
          obuf <= '{ox, oy, oz, last_q,
                    (sat_acc | s0 | s1 | s2) ? ERR_SAT : ERR_OK};
          ovalid <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result beat appears only at the end of a transform or a failed-geometry pass.
  `CPBM_ASSERT_NEXT(a_out_src, $rose(ovalid), $past(state) == S_OUT || $past(state) == S_IDLE)
  // No input is taken while a result waits.
  `CPBM_ASSERT_IMP(a_no_accept_while_held, ovalid, !in_ch.ready)
  // The shared unit finishes only while the sequencer waits for it.
  `CPBM_ASSERT_IMP(a_done_in_wait, alu_done, state == S_WAIT)

endmodule
